[src/arpc_pkg.sv]
`default_nettype none
package arpc_pkg;

  localparam int CACHE_ENTRIES_DEF   = 16;
  localparam int PENDING_TARGETS_DEF = 8;
  localparam int QUEUE_SLOTS_DEF     = 16;
  localparam int TAG_BITS_DEF        = 8;

  localparam int AGE_W = 20;

  localparam logic [AGE_W-1:0] LIFETIME_RST = 20'd30000;
  localparam logic [AGE_W-1:0] HOLDOFF_RST  = 20'd5000;

  localparam logic [47:0] MAC_BCAST = 48'hFFFF_FFFF_FFFF;

  localparam logic [15:0] ETH_IPV4 = 16'h0800;
  localparam logic [15:0] ETH_ARP  = 16'h0806;
  localparam logic [15:0] ARP_OP_REQUEST = 16'd1;

  typedef enum logic [1:0] {
    FUNC_SEND = 2'd0,
    FUNC_RECV = 2'd1,
    FUNC_TICK = 2'd2
  } func_t;

  typedef enum logic [2:0] {
    KIND_IPV4    = 3'd0,
    KIND_ARP_REQ = 3'd1,
    KIND_ARP_REP = 3'd2,
    KIND_DELIVER = 3'd3,
    KIND_DROP    = 3'd4
  } kind_t;

  typedef enum logic [1:0] {
    REG_OWN_MAC  = 2'd0,
    REG_OWN_IP   = 2'd1,
    REG_LIFETIME = 2'd2,
    REG_HOLDOFF  = 2'd3
  } reg_idx_t;

endpackage
`default_nettype wire

[src/arp_resolver_with_cache.sv]
// Channel  Direction  Handshake               Payload
// s_axis   in         tvalid/tready           tuser func, tdata request fields
// m_axis   out        tvalid/tready/tlast     tuser out_kind, tdata result fields
// apb      in         psel/penable/pwrite     four config registers, 8-byte stride
//
// Send scans the cache table and, on a miss, the pending table.
// An ARP frame scans the cache, the pending table and the queue.
// A tick ages the cache and pending tables. One item at a time: s_axis_tready
// is high only in idle, after the previous transaction has finished.
// A stalled m_axis holds the sequencer at the next result.
// Reset clears all valid bits and queue pointers.
`default_nettype none
module arp_resolver_with_cache #(
  parameter int CACHE_ENTRIES   = arpc_pkg::CACHE_ENTRIES_DEF,
  parameter int PENDING_TARGETS = arpc_pkg::PENDING_TARGETS_DEF,
  parameter int QUEUE_SLOTS     = arpc_pkg::QUEUE_SLOTS_DEF,
  parameter int TAG_BITS        = arpc_pkg::TAG_BITS_DEF,
  localparam int IW = ((241 + TAG_BITS + 7) / 8) * 8,
  localparam int OW = ((80 + TAG_BITS + 7) / 8) * 8
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          s_axis_tvalid,
  output logic               s_axis_tready,
  // hop_ip, datagram_tag, frame_dst_mac, frame_ethertype, payload_ok,
  // arp_opcode, arp_sender_mac, arp_sender_ip, arp_target_ip, elapsed_ms
  input  wire logic [IW-1:0] s_axis_tdata,
  // func
  input  wire logic [1:0]    s_axis_tuser,
  output logic               m_axis_tvalid,
  input  wire logic          m_axis_tready,
  // dst_mac, target_ip, out_tag
  output logic [OW-1:0]      m_axis_tdata,
  // out_kind
  output logic [2:0]         m_axis_tuser,
  output logic               m_axis_tlast,
  input  wire logic          psel,
  input  wire logic          penable,
  input  wire logic          pwrite,
  input  wire logic [4:0]    paddr,
  input  wire logic [63:0]   pwdata,
  output logic [63:0]        prdata,
  output logic               pready
);

  localparam int AW = arpc_pkg::AGE_W;
  localparam int CW = (CACHE_ENTRIES > 1) ? $clog2(CACHE_ENTRIES) : 1;
  localparam int PW = (PENDING_TARGETS > 1) ? $clog2(PENDING_TARGETS) : 1;
  localparam int QW = (QUEUE_SLOTS > 1) ? $clog2(QUEUE_SLOTS) : 1;
  localparam int SW = (CW > PW) ? CW : PW;

  typedef enum logic [3:0] {
    S_IDLE, S_CSCAN, S_PSCAN, S_PREQ, S_QUEUE, S_DELIV, S_LSCAN, S_LWRITE,
    S_LPEND, S_FLUSH, S_HEAD, S_REPLY, S_TCACHE, S_TPEND, S_FIN
  } state_t;

  state_t state;

  logic [47:0]   own_mac;
  logic [31:0]   own_ip;
  logic [AW-1:0] lifetime;
  logic [AW-1:0] holdoff;

  logic [CACHE_ENTRIES-1:0] cache_valid;
  logic [31:0]   cache_ip  [CACHE_ENTRIES];
  logic [47:0]   cache_mac [CACHE_ENTRIES];
  logic [AW-1:0] cache_age [CACHE_ENTRIES];
  logic [PENDING_TARGETS-1:0] pending_valid;
  logic [31:0]   pending_ip  [PENDING_TARGETS];
  logic [AW-1:0] pending_age [PENDING_TARGETS];
  logic [QUEUE_SLOTS-1:0] queue_valid;
  logic [31:0]         queue_ip  [QUEUE_SLOTS];
  logic [TAG_BITS-1:0] queue_tag [QUEUE_SLOTS];
  logic [QW-1:0] queue_head;
  logic [QW-1:0] queue_tail;

  logic [31:0]         hop_ip;
  logic [TAG_BITS-1:0] tag;
  logic [15:0]         opcode;
  logic [47:0]         smac;
  logic [31:0]         sip;
  logic [31:0]         tip;
  logic [15:0]         elapsed;

  logic [CW-1:0] ci;
  logic [PW-1:0] pi;
  logic [QW-1:0] qs;
  logic [QW-1:0] qk;
  logic          match;
  logic [CW-1:0] cslot;
  logic [PW-1:0] pslot;
  logic          ff_found;
  logic [SW-1:0] ff_idx;
  logic [SW-1:0] best_idx;
  logic [AW-1:0] best_age;

  logic          have_prev;
  logic [2:0]    prev_kind;
  logic [47:0]   prev_mac;
  logic [31:0]   prev_ip;
  logic [TAG_BITS-1:0] prev_tag;
  logic [2:0]    out_kind;
  logic [47:0]   out_mac;
  logic [31:0]   out_ip;
  logic [TAG_BITS-1:0] out_tag;

  logic          em_req;
  logic [2:0]    em_kind;
  logic [47:0]   em_mac;
  logic [31:0]   em_ip;
  logic [TAG_BITS-1:0] em_tag;
  logic          out_free;
  logic          stall;
  logic          push_mid;
  logic          push_fin;

  logic          trk_valid;
  logic [AW-1:0] trk_age;
  logic [SW-1:0] trk_i;
  logic          ff_found_next;
  logic [SW-1:0] ff_idx_next;
  logic [SW-1:0] best_idx_next;
  logic [AW-1:0] best_age_next;
  logic [SW-1:0] slot_next;

  logic [AW-1:0] age_in;
  logic [AW:0]   age_sum;
  logic [AW-1:0] age_next;

  logic          for_us;
  logic          c_hit;
  logic          p_hit;
  logic          q_hit;
  logic [QW-1:0] qs_inc;
  logic [QW-1:0] head_inc;
  logic [QW-1:0] tail_inc;
  logic          cfg_wr;

  assign pready        = 1'b1;
  assign cfg_wr        = psel && penable && pwrite && pready;
  assign s_axis_tready = (state == S_IDLE);
  assign m_axis_tdata  = OW'({out_tag, out_ip, out_mac});
  assign m_axis_tuser  = out_kind;

  always_comb begin
    case (arpc_pkg::reg_idx_t'(paddr[4:3]))
      arpc_pkg::REG_OWN_MAC:  prdata = {16'd0, own_mac};
      arpc_pkg::REG_OWN_IP:   prdata = {32'd0, own_ip};
      arpc_pkg::REG_LIFETIME: prdata = {44'd0, lifetime};
      arpc_pkg::REG_HOLDOFF:  prdata = {44'd0, holdoff};
      default:                prdata = '0;
    endcase
  end

  assign for_us = ((s_axis_tdata[40+TAG_BITS-8 +: 48] == own_mac) ||
                   (s_axis_tdata[40+TAG_BITS-8 +: 48] == arpc_pkg::MAC_BCAST)) &&
                  s_axis_tdata[104+TAG_BITS-8];

  assign c_hit = cache_valid[ci] && (cache_ip[ci] == ((state == S_CSCAN) ? hop_ip : sip));
  assign p_hit = pending_valid[pi] && (pending_ip[pi] == ((state == S_PSCAN) ? hop_ip : sip));
  assign q_hit = queue_valid[qs] && (queue_ip[qs] == sip);

  assign qs_inc   = (qs == QW'(QUEUE_SLOTS - 1)) ? '0 : qs + QW'(1);
  assign head_inc = (queue_head == QW'(QUEUE_SLOTS - 1)) ? '0 : queue_head + QW'(1);
  assign tail_inc = (queue_tail == QW'(QUEUE_SLOTS - 1)) ? '0 : queue_tail + QW'(1);

  // oldest-entry / first-free tracker shared by the cache and pending scans
  always_comb begin
    if (state == S_PSCAN) begin
      trk_valid = pending_valid[pi];
      trk_age   = pending_age[pi];
      trk_i     = SW'(pi);
    end else begin
      trk_valid = cache_valid[ci];
      trk_age   = cache_age[ci];
      trk_i     = SW'(ci);
    end
    ff_found_next = ff_found;
    ff_idx_next   = ff_idx;
    best_idx_next = best_idx;
    best_age_next = best_age;
    if (!ff_found && !trk_valid) begin
      ff_found_next = 1'b1;
      ff_idx_next   = trk_i;
    end
    if (trk_i == '0) begin
      best_idx_next = '0;
      best_age_next = trk_age;
    end else if (trk_valid && (trk_age > best_age)) begin
      best_idx_next = trk_i;
      best_age_next = trk_age;
    end
    slot_next = ff_found_next ? ff_idx_next : best_idx_next;
  end

  // shared saturating age adder
  always_comb begin
    age_in   = (state == S_TPEND) ? pending_age[pi] : cache_age[ci];
    age_sum  = {1'b0, age_in} + {{(AW - 15){1'b0}}, elapsed};
    age_next = age_sum[AW] ? {AW{1'b1}} : age_sum[AW-1:0];
  end

  always_comb begin
    em_req  = 1'b0;
    em_kind = arpc_pkg::KIND_IPV4;
    em_mac  = '0;
    em_ip   = '0;
    em_tag  = '0;
    case (state)
      S_CSCAN: begin
        em_req = c_hit;
        em_mac = cache_mac[ci];
        em_ip  = hop_ip;
        em_tag = tag;
      end
      S_PREQ: begin
        em_req  = 1'b1;
        em_kind = arpc_pkg::KIND_ARP_REQ;
        em_mac  = arpc_pkg::MAC_BCAST;
        em_ip   = hop_ip;
      end
      S_QUEUE: begin
        em_req  = queue_valid[queue_tail];
        em_kind = arpc_pkg::KIND_DROP;
        em_ip   = hop_ip;
        em_tag  = tag;
      end
      S_DELIV: begin
        em_req  = 1'b1;
        em_kind = arpc_pkg::KIND_DELIVER;
      end
      S_FLUSH: begin
        em_req = q_hit;
        em_mac = smac;
        em_ip  = sip;
        em_tag = queue_tag[qs];
      end
      S_REPLY: begin
        em_req  = (opcode == arpc_pkg::ARP_OP_REQUEST) && (tip == own_ip);
        em_kind = arpc_pkg::KIND_ARP_REP;
        em_mac  = smac;
        em_ip   = sip;
      end
      default: em_req = 1'b0;
    endcase
  end

  assign out_free = !m_axis_tvalid || m_axis_tready;
  assign stall    = em_req && have_prev && !out_free;
  assign push_mid = em_req && !stall && have_prev;
  assign push_fin = (state == S_FIN) && have_prev && out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      own_mac       <= '0;
      own_ip        <= '0;
      lifetime      <= arpc_pkg::LIFETIME_RST;
      holdoff       <= arpc_pkg::HOLDOFF_RST;
      cache_valid   <= '0;
      pending_valid <= '0;
      queue_valid   <= '0;
      queue_head    <= '0;
      queue_tail    <= '0;
      have_prev     <= 1'b0;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (cfg_wr) begin
        case (arpc_pkg::reg_idx_t'(paddr[4:3]))
          arpc_pkg::REG_OWN_MAC:  own_mac  <= pwdata[47:0];
          arpc_pkg::REG_OWN_IP:   own_ip   <= pwdata[31:0];
          arpc_pkg::REG_LIFETIME: lifetime <= pwdata[AW-1:0];
          arpc_pkg::REG_HOLDOFF:  holdoff  <= pwdata[AW-1:0];
          default: ;
        endcase
      end

      if (push_mid || push_fin) begin
        m_axis_tvalid <= 1'b1;
        m_axis_tlast  <= push_fin;
        out_kind      <= prev_kind;
        out_mac       <= prev_mac;
        out_ip        <= prev_ip;
        out_tag       <= prev_tag;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end

      if (em_req && !stall) begin
        have_prev <= 1'b1;
        prev_kind <= em_kind;
        prev_mac  <= em_mac;
        prev_ip   <= em_ip;
        prev_tag  <= em_tag;
      end

      if (!stall) begin
        case (state)
          S_IDLE: begin
            if (s_axis_tvalid) begin
              hop_ip  <= s_axis_tdata[31:0];
              tag     <= s_axis_tdata[32 +: TAG_BITS];
              opcode  <= s_axis_tdata[105+TAG_BITS-8 +: 16];
              smac    <= s_axis_tdata[121+TAG_BITS-8 +: 48];
              sip     <= s_axis_tdata[169+TAG_BITS-8 +: 32];
              tip     <= s_axis_tdata[201+TAG_BITS-8 +: 32];
              elapsed <= s_axis_tdata[233+TAG_BITS-8 +: 16];
              ci       <= '0;
              pi       <= '0;
              match    <= 1'b0;
              ff_found <= 1'b0;
              case (arpc_pkg::func_t'(s_axis_tuser))
                arpc_pkg::FUNC_SEND: state <= S_CSCAN;
                arpc_pkg::FUNC_RECV: begin
                  if (for_us &&
                      (s_axis_tdata[88+TAG_BITS-8 +: 16] == arpc_pkg::ETH_IPV4)) begin
                    state <= S_DELIV;
                  end else if (for_us &&
                               (s_axis_tdata[88+TAG_BITS-8 +: 16] == arpc_pkg::ETH_ARP)) begin
                    state <= S_LSCAN;
                  end
                end
                arpc_pkg::FUNC_TICK: state <= S_TCACHE;
                default: ;
              endcase
            end
          end
          S_CSCAN: begin
            if (c_hit) begin
              state <= S_FIN;
            end else if (ci == CW'(CACHE_ENTRIES - 1)) begin
              state <= S_PSCAN;
            end else begin
              ci <= ci + CW'(1);
            end
          end
          S_PSCAN: begin
            ff_found <= ff_found_next;
            ff_idx   <= ff_idx_next;
            best_idx <= best_idx_next;
            best_age <= best_age_next;
            if (p_hit) begin
              match <= 1'b1;
            end
            if (pi == PW'(PENDING_TARGETS - 1)) begin
              pslot <= PW'(slot_next);
              state <= (match || p_hit) ? S_QUEUE : S_PREQ;
            end else begin
              pi <= pi + PW'(1);
            end
          end
          S_PREQ: begin
            pending_valid[pslot] <= 1'b1;
            pending_ip[pslot]    <= hop_ip;
            pending_age[pslot]   <= '0;
            state                <= S_QUEUE;
          end
          S_QUEUE: begin
            if (!queue_valid[queue_tail]) begin
              queue_valid[queue_tail] <= 1'b1;
              queue_ip[queue_tail]    <= hop_ip;
              queue_tag[queue_tail]   <= tag;
              queue_tail              <= tail_inc;
            end
            state <= S_FIN;
          end
          S_DELIV: state <= S_FIN;
          S_LSCAN: begin
            ff_found <= ff_found_next;
            ff_idx   <= ff_idx_next;
            best_idx <= best_idx_next;
            best_age <= best_age_next;
            if (c_hit) begin
              match <= 1'b1;
              cslot <= ci;
            end
            if (ci == CW'(CACHE_ENTRIES - 1)) begin
              if (!(c_hit || match)) begin
                cslot <= CW'(slot_next);
              end
              state <= S_LWRITE;
            end else begin
              ci <= ci + CW'(1);
            end
          end
          S_LWRITE: begin
            cache_valid[cslot] <= 1'b1;
            cache_ip[cslot]    <= sip;
            cache_mac[cslot]   <= smac;
            cache_age[cslot]   <= '0;
            state              <= S_LPEND;
          end
          S_LPEND: begin
            if (p_hit) begin
              pending_valid[pi] <= 1'b0;
            end
            if (pi == PW'(PENDING_TARGETS - 1)) begin
              qs    <= queue_head;
              qk    <= '0;
              state <= S_FLUSH;
            end else begin
              pi <= pi + PW'(1);
            end
          end
          S_FLUSH: begin
            if (q_hit) begin
              queue_valid[qs] <= 1'b0;
            end
            qs <= qs_inc;
            if (qk == QW'(QUEUE_SLOTS - 1)) begin
              state <= S_HEAD;
            end else begin
              qk <= qk + QW'(1);
            end
          end
          S_HEAD: begin
            if (queue_valid == '0) begin
              queue_head <= queue_tail;
              state      <= S_REPLY;
            end else if (!queue_valid[queue_head]) begin
              queue_head <= head_inc;
            end else begin
              state <= S_REPLY;
            end
          end
          S_REPLY: state <= S_FIN;
          S_TCACHE: begin
            if (cache_valid[ci]) begin
              cache_age[ci] <= age_next;
              if (age_next >= lifetime) begin
                cache_valid[ci] <= 1'b0;
              end
            end
            if (ci == CW'(CACHE_ENTRIES - 1)) begin
              state <= S_TPEND;
            end else begin
              ci <= ci + CW'(1);
            end
          end
          S_TPEND: begin
            if (pending_valid[pi]) begin
              pending_age[pi] <= age_next;
              if (age_next >= holdoff) begin
                pending_valid[pi] <= 1'b0;
              end
            end
            if (pi == PW'(PENDING_TARGETS - 1)) begin
              state <= S_FIN;
            end else begin
              pi <= pi + PW'(1);
            end
          end
          S_FIN: begin
            if (!have_prev) begin
              state <= S_IDLE;
            end else if (out_free) begin
              have_prev <= 1'b0;
              state     <= S_IDLE;
            end
          end
          default: state <= S_IDLE;
        endcase
      end
    end
  end

`ifndef SYNTHESIS
  a_idle_no_held: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |-> !have_prev)
    else $error("held result left in idle");

  a_busy_after_send: assert property (@(posedge clk) disable iff (rst)
    (s_axis_tvalid && s_axis_tready && (s_axis_tuser == arpc_pkg::FUNC_SEND))
      |=> !s_axis_tready)
    else $error("ready right after accepted send");

  a_hold_stalled: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
    else $error("stalled result changed");
`endif

endmodule
`default_nettype wire

[verif/testbench.sv]
`timescale 1ns / 1ps
`default_nettype none
module testbench;

  typedef struct {
    logic [1:0]  func;
    logic [31:0] hop;
    logic [7:0]  tag;
    logic [47:0] dst_mac;
    logic [15:0] etype;
    logic        ok;
    logic [15:0] opcode;
    logic [47:0] snd_mac;
    logic [31:0] snd_ip;
    logic [31:0] tgt_ip;
    logic [15:0] elapsed;
  } arp_item_t;

  typedef struct {
    arpc_pkg::kind_t kind;
    logic [47:0] mac;
    logic [31:0] ip;
    logic [7:0]  tag;
    logic        last;
  } arp_result_t;

  typedef struct {
    arp_item_t   item;
    bit          typed;
    int          n_typed;
    arp_result_t res;
  } vector_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  // hop_ip, datagram_tag, frame_dst_mac, frame_ethertype, payload_ok,
  // arp_opcode, arp_sender_mac, arp_sender_ip, arp_target_ip, elapsed_ms
  logic [255:0] s_axis_tdata = '0;
  // func
  logic [1:0] s_axis_tuser = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  // dst_mac, target_ip, out_tag
  logic [87:0] m_axis_tdata;
  // out_kind
  logic [2:0] m_axis_tuser;
  logic m_axis_tlast;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [4:0] paddr = '0;
  logic [63:0] pwdata = '0;
  logic [63:0] prdata;
  logic pready;

  arp_resolver_with_cache u_dut (.*);

  always #2 clk = ~clk;

  // predictor state
  logic [47:0] my_mac;
  logic [31:0] my_ip;
  logic [19:0] lifetime, holdoff;
  bit          c_valid [16];
  logic [31:0] c_ip [16];
  logic [47:0] c_mac [16];
  logic [19:0] c_age [16];
  bit          p_valid [8];
  logic [31:0] p_ip [8];
  logic [19:0] p_age [8];
  bit          q_valid [16];
  logic [31:0] q_ip [16];
  logic [7:0]  q_tag [16];
  logic [3:0]  q_head, q_tail;

  arp_result_t pending_frames [$];
  int  errors = 0;
  bit  quiet = 1'b0;
  logic [31:0] ip_pool [24];
  logic [47:0] mac_pool [24];

  task automatic flag(string msg);
    $display("mismatch at %0t: %s", $realtime, msg);
    errors++;
  endtask

  function automatic void add_frame(arpc_pkg::kind_t k, logic [47:0] mac, logic [31:0] ip,
                                    logic [7:0] tag);
    arp_result_t r;
    r.kind = k; r.mac = mac; r.ip = ip; r.tag = tag; r.last = 1'b0;
    pending_frames.insert(pending_frames.size(), r);
  endfunction

  function automatic logic [19:0] aged(logic [19:0] a, logic [15:0] d);
    logic [20:0] s;
    s = a + d;
    return s > 21'hFFFFF ? 20'hFFFFF : s[19:0];
  endfunction

  function automatic void learn_mapping(logic [31:0] ip, logic [47:0] mac);
    int slot;
    slot = -1;
    for (int i = 0; i < 16; i++) if (c_valid[i] && c_ip[i] == ip) slot = i;
    if (slot < 0) begin
      for (int i = 15; i >= 0; i--) if (!c_valid[i]) slot = i;
      if (slot < 0) begin
        slot = 0;
        for (int i = 1; i < 16; i++) if (c_age[i] > c_age[slot]) slot = i;
      end
    end
    c_valid[slot] = 1; c_ip[slot] = ip; c_mac[slot] = mac; c_age[slot] = '0;
    for (int i = 0; i < 8; i++) if (p_valid[i] && p_ip[i] == ip) p_valid[i] = 0;
  endfunction

  function automatic void release_tags(logic [31:0] ip, logic [47:0] mac);
    logic [3:0] s;
    bit any;
    s = q_head;
    any = 0;
    for (int k = 0; k < 16; k++) begin
      if (q_valid[s] && q_ip[s] == ip) begin
        add_frame(arpc_pkg::KIND_IPV4, mac, ip, q_tag[s]);
        q_valid[s] = 0;
      end
      s++;
    end
    for (int k = 0; k < 16; k++) if (q_valid[k]) any = 1;
    if (!any) q_head = q_tail;
    else for (int k = 0; k < 16 && !q_valid[q_head]; k++) q_head++;
  endfunction

  function automatic void resolve_send(logic [31:0] ip, logic [7:0] tag);
    int p;
    bit waiting;
    for (int i = 0; i < 16; i++)
      if (c_valid[i] && c_ip[i] == ip) begin
        add_frame(arpc_pkg::KIND_IPV4, c_mac[i], ip, tag);
        return;
      end
    waiting = 0;
    for (int i = 0; i < 8; i++) if (p_valid[i] && p_ip[i] == ip) waiting = 1;
    if (!waiting) begin
      p = -1;
      for (int i = 7; i >= 0; i--) if (!p_valid[i]) p = i;
      if (p < 0) begin
        p = 0;
        for (int i = 1; i < 8; i++) if (p_age[i] > p_age[p]) p = i;
      end
      p_valid[p] = 1; p_ip[p] = ip; p_age[p] = '0;
      add_frame(arpc_pkg::KIND_ARP_REQ, arpc_pkg::MAC_BCAST, ip, 8'd0);
    end
    if (q_valid[q_tail]) begin
      add_frame(arpc_pkg::KIND_DROP, 48'd0, ip, tag);
    end else begin
      q_valid[q_tail] = 1; q_ip[q_tail] = ip; q_tag[q_tail] = tag;
      q_tail++;
    end
  endfunction

  function automatic void predict_item(arp_item_t it);
    int start;
    start = pending_frames.size();
    if (it.func == arpc_pkg::FUNC_SEND) begin
      resolve_send(it.hop, it.tag);
    end else if (it.func == arpc_pkg::FUNC_RECV) begin
      if ((it.dst_mac == my_mac || it.dst_mac == arpc_pkg::MAC_BCAST) && it.ok) begin
        if (it.etype == arpc_pkg::ETH_IPV4) begin
          add_frame(arpc_pkg::KIND_DELIVER, 48'd0, 32'd0, 8'd0);
        end else if (it.etype == arpc_pkg::ETH_ARP) begin
          learn_mapping(it.snd_ip, it.snd_mac);
          release_tags(it.snd_ip, it.snd_mac);
          if (it.opcode == arpc_pkg::ARP_OP_REQUEST && it.tgt_ip == my_ip)
            add_frame(arpc_pkg::KIND_ARP_REP, it.snd_mac, it.snd_ip, 8'd0);
        end
      end
    end else if (it.func == arpc_pkg::FUNC_TICK) begin
      for (int i = 0; i < 16; i++) if (c_valid[i]) begin
        c_age[i] = aged(c_age[i], it.elapsed);
        if (c_age[i] >= lifetime) c_valid[i] = 0;
      end
      for (int i = 0; i < 8; i++) if (p_valid[i]) begin
        p_age[i] = aged(p_age[i], it.elapsed);
        if (p_age[i] >= holdoff) p_valid[i] = 0;
      end
    end
    if (pending_frames.size() > start) pending_frames[$].last = 1'b1;
  endfunction

  function automatic bit stall();
    return !quiet && $urandom_range(99) < 33;
  endfunction

  task automatic push_item(arp_item_t it, bit typed = 0, int n_typed = 0,
                           arp_result_t res = '{arpc_pkg::KIND_IPV4, '0, '0, '0, 1'b0});
    int start;
    if (stall()) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= it.func;
    s_axis_tdata  <= {7'd0, it.elapsed, it.tgt_ip, it.snd_ip, it.snd_mac, it.opcode,
                      it.ok, it.etype, it.dst_mac, it.tag, it.hop};
    do @(posedge clk); while (!s_axis_tready);
    start = pending_frames.size();
    predict_item(it);
    if (typed) begin
      while (pending_frames.size() > start) pending_frames.pop_back();
      if (n_typed > 0) pending_frames.insert(pending_frames.size(), res);
    end
  endtask

  task automatic apb_write(arpc_pkg::reg_idx_t r, logic [63:0] v);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= 5'(r) << 3; pwdata <= v;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    case (r)
      arpc_pkg::REG_OWN_MAC:  my_mac = v[47:0];
      arpc_pkg::REG_OWN_IP:   my_ip = v[31:0];
      arpc_pkg::REG_LIFETIME: lifetime = v[19:0];
      arpc_pkg::REG_HOLDOFF:  holdoff = v[19:0];
      default: ;
    endcase
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (pending_frames.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
  endtask

  function automatic logic [47:0] rand_mac();
    return 48'({$urandom, $urandom});
  endfunction

  function automatic arp_item_t blank(logic [1:0] f);
    arp_item_t it;
    it = '{f, '0, '0, '0, '0, 1'b0, '0, '0, '0, '0, '0};
    return it;
  endfunction

  function automatic arp_item_t arp_frame(logic [47:0] dst, logic [15:0] op,
                                          logic [47:0] smac, logic [31:0] sip,
                                          logic [31:0] tip);
    arp_item_t it;
    it = blank(arpc_pkg::FUNC_RECV);
    it.dst_mac = dst; it.etype = arpc_pkg::ETH_ARP; it.ok = 1'b1; it.opcode = op;
    it.snd_mac = smac; it.snd_ip = sip; it.tgt_ip = tip;
    return it;
  endfunction

  function automatic arp_item_t random_item();
    arp_item_t it;
    int k, sel;
    k = $urandom_range(23);
    sel = $urandom_range(99);
    it = blank(arpc_pkg::FUNC_SEND);
    if (sel < 40) begin
      it.hop = ip_pool[k];
      it.tag = 8'($urandom);
    end else if (sel < 65) begin
      it = arp_frame($urandom_range(1) ? my_mac : arpc_pkg::MAC_BCAST,
                     $urandom_range(4) == 0 ? 16'($urandom) : 16'($urandom_range(1, 2)),
                     $urandom_range(7) == 0 ? rand_mac() : mac_pool[k], ip_pool[k],
                     $urandom_range(1) ? my_ip : $urandom);
      it.ok = $urandom_range(9) != 0;
    end else if (sel < 80) begin
      it = blank(arpc_pkg::FUNC_TICK);
      it.elapsed = $urandom_range(9) == 0 ? 16'($urandom) : 16'($urandom_range(0, 1500));
    end else begin
      it = '{2'($urandom), $urandom, 8'($urandom), rand_mac(), 16'($urandom),
             1'($urandom), 16'($urandom), rand_mac(), $urandom, $urandom, 16'($urandom)};
      if ($urandom_range(1)) it.dst_mac = arpc_pkg::MAC_BCAST;
      if ($urandom_range(1))
        it.etype = $urandom_range(1) ? arpc_pkg::ETH_ARP : arpc_pkg::ETH_IPV4;
    end
    return it;
  endfunction

  always @(posedge clk) begin
    arp_result_t e;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (pending_frames.size() == 0) begin
        flag($sformatf("unexpected transaction kind %0d", m_axis_tuser));
      end else begin
        e = pending_frames.pop_front();
        if (m_axis_tuser !== e.kind)
          flag($sformatf("kind %0d, want %0d", m_axis_tuser, e.kind));
        if (m_axis_tdata[47:0] !== e.mac)
          flag($sformatf("dst_mac %h, want %h", m_axis_tdata[47:0], e.mac));
        if (m_axis_tdata[79:48] !== e.ip)
          flag($sformatf("target_ip %h, want %h", m_axis_tdata[79:48], e.ip));
        if (m_axis_tdata[87:80] !== e.tag)
          flag($sformatf("tag %h, want %h", m_axis_tdata[87:80], e.tag));
        if (m_axis_tlast !== e.last)
          flag($sformatf("last %b, want %b", m_axis_tlast, e.last));
      end
    end
    m_axis_tready <= rst ? 1'b0 : !stall();
  end

  initial begin
    vector_t vectors [14];
    arp_item_t it;
    logic [31:0] ip_a, ip_b;
    logic [47:0] mac_a, mac_b;
    ip_a = 32'hC0A8_0001; ip_b = 32'h0A00_0002;
    mac_a = 48'h0200_1122_3344; mac_b = 48'hFFFF_FFFF_FFFE;
    my_mac = '0; my_ip = '0;
    lifetime = arpc_pkg::LIFETIME_RST; holdoff = arpc_pkg::HOLDOFF_RST;
    foreach (c_valid[i]) c_valid[i] = 0;
    foreach (p_valid[i]) p_valid[i] = 0;
    foreach (q_valid[i]) q_valid[i] = 0;
    q_head = '0; q_tail = '0;
    for (int k = 0; k < 24; k++) begin
      ip_pool[k] = {8'h0A, 16'($urandom), 8'(k)};
      mac_pool[k] = rand_mac();
    end

    it = blank(arpc_pkg::FUNC_RECV); it.dst_mac = arpc_pkg::MAC_BCAST;
    it.etype = arpc_pkg::ETH_IPV4; it.ok = 1;
    vectors[0] = '{it, 1, 1, '{arpc_pkg::KIND_DELIVER, '0, '0, '0, 1'b1}};
    it.dst_mac = '0;
    vectors[1] = '{it, 1, 1, '{arpc_pkg::KIND_DELIVER, '0, '0, '0, 1'b1}};
    it.ok = 0;
    vectors[2] = '{it, 1, 0, '{arpc_pkg::KIND_DELIVER, '0, '0, '0, 1'b0}};
    it.ok = 1; it.dst_mac = 48'h0000_0000_0001;
    vectors[3] = '{it, 1, 0, '{arpc_pkg::KIND_DELIVER, '0, '0, '0, 1'b0}};
    it = blank(arpc_pkg::FUNC_SEND); it.hop = ip_a; it.tag = 8'hFF;
    vectors[4] = '{it, 1, 1, '{arpc_pkg::KIND_ARP_REQ, arpc_pkg::MAC_BCAST, ip_a, 8'd0, 1'b1}};
    it.tag = 8'h00;
    vectors[5] = '{it, 1, 0, '{arpc_pkg::KIND_DELIVER, '0, '0, '0, 1'b0}};
    it = arp_frame(arpc_pkg::MAC_BCAST, 16'd2, mac_a, ip_a, 32'hFFFF_FFFF);
    vectors[6] = '{it, 0, 0, '{arpc_pkg::KIND_DELIVER, '0, '0, '0, 1'b0}};
    it = blank(arpc_pkg::FUNC_SEND); it.hop = ip_a; it.tag = 8'h5A;
    vectors[7] = '{it, 1, 1, '{arpc_pkg::KIND_IPV4, mac_a, ip_a, 8'h5A, 1'b1}};
    it = arp_frame(48'd0, arpc_pkg::ARP_OP_REQUEST, mac_b, ip_b, 32'd0);
    vectors[8] = '{it, 0, 0, '{arpc_pkg::KIND_DELIVER, '0, '0, '0, 1'b0}};
    it = blank(2'd3); it.hop = '1; it.dst_mac = arpc_pkg::MAC_BCAST;
    it.etype = arpc_pkg::ETH_IPV4; it.ok = 1;
    vectors[9] = '{it, 1, 0, '{arpc_pkg::KIND_DELIVER, '0, '0, '0, 1'b0}};
    it = blank(arpc_pkg::FUNC_TICK); it.elapsed = 16'hFFFF;
    vectors[10] = '{it, 1, 0, '{arpc_pkg::KIND_DELIVER, '0, '0, '0, 1'b0}};
    it = blank(arpc_pkg::FUNC_SEND); it.hop = 32'hFFFF_FFFF; it.tag = 8'hFF;
    vectors[11] = '{it, 1, 1, '{arpc_pkg::KIND_ARP_REQ, arpc_pkg::MAC_BCAST, 32'hFFFF_FFFF,
                               8'd0, 1'b1}};
    it.hop = 32'd0;
    vectors[12] = '{it, 1, 1, '{arpc_pkg::KIND_ARP_REQ, arpc_pkg::MAC_BCAST, 32'd0, 8'd0,
                               1'b1}};
    it = arp_frame(arpc_pkg::MAC_BCAST, 16'hFFFF, 48'hFFFF_FFFF_FFFF, 32'hFFFF_FFFF, 32'd0);
    vectors[13] = '{it, 0, 0, '{arpc_pkg::KIND_DELIVER, '0, '0, '0, 1'b0}};

    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    foreach (vectors[i])
      push_item(vectors[i].item, vectors[i].typed, vectors[i].n_typed, vectors[i].res);

    for (int phase = 0; phase < 4; phase++) begin
      drain();
      case (phase)
        0: begin
          apb_write(arpc_pkg::REG_OWN_MAC, 64'h0000_FFFF_FFFF_FFFF);
          apb_write(arpc_pkg::REG_OWN_IP, 64'h0000_0000_FFFF_FFFF);
          apb_write(arpc_pkg::REG_LIFETIME, 64'd1);
          apb_write(arpc_pkg::REG_HOLDOFF, 64'hFFFFF);
        end
        1: begin
          apb_write(arpc_pkg::REG_OWN_MAC, 64'(rand_mac()));
          apb_write(arpc_pkg::REG_OWN_IP, 64'($urandom));
          apb_write(arpc_pkg::REG_LIFETIME, 64'hFFFFF);
          apb_write(arpc_pkg::REG_HOLDOFF, 64'd1);
        end
        2: begin
          apb_write(arpc_pkg::REG_OWN_MAC, 64'd0);
          apb_write(arpc_pkg::REG_OWN_IP, 64'd0);
          apb_write(arpc_pkg::REG_LIFETIME, 64'd2500);
          apb_write(arpc_pkg::REG_HOLDOFF, 64'd700);
        end
        default: begin
          apb_write(arpc_pkg::REG_OWN_MAC, 64'(rand_mac()));
          apb_write(arpc_pkg::REG_OWN_IP, 64'(ip_pool[3]));
          apb_write(arpc_pkg::REG_LIFETIME, 64'd6000);
          apb_write(arpc_pkg::REG_HOLDOFF, 64'd2000);
        end
      endcase
      for (int n = 0; n < 40; n++) begin
        quiet = (phase == 2 && n < 25);
        push_item(random_item());
      end
    end
    quiet = 0;
    drain();
    if (errors == 0) $display("testbench: clean");
    else $display("testbench: errors");
    $finish;
  end

  initial begin
    #5ms;
    $display("testbench: errors");
    $finish;
  end

endmodule
`default_nettype wire
